// ----- rtl/tbb_pkg.sv -----
// Shared types, constants and the beat size table of the tick to bar/beat converter.
package tbb_pkg;

  localparam int TICK_W     = 40;
  localparam int BAR_W      = 41;
  localparam int BEAT_SZ_W  = 12;
  localparam int BAR_SZ_W   = 18;
  localparam int SIX_SZ_W   = 10;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BEATS_PER_BAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_UNIT     = 1'b1;

  localparam logic       OP_SPLIT   = 1'b0;
  localparam logic       OP_REBUILD = 1'b1;

  // Ticks in one beat at 960 ticks per quarter, indexed by the denominator.
  // A denominator of zero acts as one.
  localparam logic [BEAT_SZ_W-1:0] BEAT_SIZE [128] = '{
    12'd3840, 12'd3840, 12'd1920, 12'd1280, 12'd960,  12'd768,  12'd640,  12'd548,
    12'd480,  12'd426,  12'd384,  12'd349,  12'd320,  12'd295,  12'd274,  12'd256,
    12'd240,  12'd225,  12'd213,  12'd202,  12'd192,  12'd182,  12'd174,  12'd166,
    12'd160,  12'd153,  12'd147,  12'd142,  12'd137,  12'd132,  12'd128,  12'd123,
    12'd120,  12'd116,  12'd112,  12'd109,  12'd106,  12'd103,  12'd101,  12'd98,
    12'd96,   12'd93,   12'd91,   12'd89,   12'd87,   12'd85,   12'd83,   12'd81,
    12'd80,   12'd78,   12'd76,   12'd75,   12'd73,   12'd72,   12'd71,   12'd69,
    12'd68,   12'd67,   12'd66,   12'd65,   12'd64,   12'd62,   12'd61,   12'd60,
    12'd60,   12'd59,   12'd58,   12'd57,   12'd56,   12'd55,   12'd54,   12'd54,
    12'd53,   12'd52,   12'd51,   12'd51,   12'd50,   12'd49,   12'd49,   12'd48,
    12'd48,   12'd47,   12'd46,   12'd46,   12'd45,   12'd45,   12'd44,   12'd44,
    12'd43,   12'd43,   12'd42,   12'd42,   12'd41,   12'd41,   12'd40,   12'd40,
    12'd40,   12'd39,   12'd39,   12'd38,   12'd38,   12'd38,   12'd37,   12'd37,
    12'd36,   12'd36,   12'd36,   12'd35,   12'd35,   12'd35,   12'd34,   12'd34,
    12'd34,   12'd33,   12'd33,   12'd33,   12'd33,   12'd32,   12'd32,   12'd32,
    12'd32,   12'd31,   12'd31,   12'd31,   12'd30,   12'd30,   12'd30,   12'd30
  };

  typedef struct packed {
    logic                opcode;
    logic [TICK_W-1:0]   tick_in;
    logic [BAR_W-1:0]    bar_in;
    logic signed [7:0]   beat_in;
    logic signed [7:0]   sixteenth_in;
  } req_t;

  typedef struct packed {
    logic [BAR_W-1:0]    bar_out;
    logic [5:0]          beat_out;
    logic [2:0]          sixteenth_out;
    logic [9:0]          sub_ticks;
    logic [TICK_W-1:0]   tick_out;
    logic                overflow;
  } rsp_t;

endpackage

// ----- rtl/tbb_stream_if.sv -----
// Valid/ready stream channel carrying one request or response payload.
interface tbb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tick_to_bar_beat_converter_top.sv -----
// Top level of the tick to bar/beat/sixteenth converter.
//
// Requests arrive on req_i (valid/ready) and responses leave on rsp_o, one
// response per request, in order. Opcode 0 splits a tick count into bar,
// beat, sixteenth and leftover ticks; opcode 1 rebuilds a saturated tick
// count from bar, beat and sixteenth. The time signature is set through
// the write port cfg_we_i/cfg_idx_i/cfg_data_i while no request is in flight.
// A request is taken every cycle while the skid register is empty. Its
// response passes through four front stages, then a row of 49 division cells
// (40 for the bar, 6 for the beat, 3 for the sixteenth) that each settle one
// quotient bit, and then the output register. When the receiver stalls, one
// more response is parked in a skid register and the whole pipeline then
// holds; nothing is dropped. Reset empties the pipeline and loads a 4/4 time
// signature.
module tick_to_bar_beat_converter_top
  import tbb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tbb_stream_if.sink            req_i,
  tbb_stream_if.source          rsp_o
);

  localparam int A_N  = 40;
  localparam int B_N  = 6;
  localparam int C_N  = 3;
  localparam int PA_W = TICK_W + 2;
  localparam int PB_W = PA_W + TICK_W;
  localparam int PC_W = PB_W + B_N;

  // Time signature and derived sizes.
  logic [5:0]           num_q, num_d;
  logic [6:0]           den_q, den_d;
  logic [5:0]           num_eff;
  logic [BEAT_SZ_W-1:0] beat_sz_d, beat_sz_q;
  logic [BAR_SZ_W-1:0]  bar_sz_d, bar_sz_q;
  logic [SIX_SZ_W-1:0]  six_sz_d, six_sz_q;

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    if (cfg_we_i && cfg_idx_i == REG_BEATS_PER_BAR) begin
      num_d = cfg_data_i[5:0];
    end
    if (cfg_we_i && cfg_idx_i == REG_BEAT_UNIT) begin
      den_d = cfg_data_i;
    end
    num_eff   = (num_d == 6'd0) ? 6'd1 : num_d;
    beat_sz_d = BEAT_SIZE[den_d];
    bar_sz_d  = BAR_SZ_W'(num_eff) * BAR_SZ_W'(beat_sz_d);
    six_sz_d  = (beat_sz_d[11:2] == 10'd0) ? 10'd1 : beat_sz_d[11:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q     <= 6'd4;
      den_q     <= 7'd4;
      beat_sz_q <= 12'd960;
      bar_sz_q  <= 18'd3840;
      six_sz_q  <= 10'd240;
    end else begin
      num_q     <= num_d;
      den_q     <= den_d;
      beat_sz_q <= beat_sz_d;
      bar_sz_q  <= bar_sz_d;
      six_sz_q  <= six_sz_d;
    end
  end

  // Flow control: the pipeline moves unless the skid register is occupied.
  logic en;
  logic skid_v_q, out_v_q;
  rsp_t skid_q, out_q, res;

  assign en = !skid_v_q;
  assign req_i.ready = en;

  // Front stages: operand clean-up, partial products, sums and saturation.
  logic              v0_q, v1_q, v2_q, v3_q;
  logic              op0_q, op1_q, op2_q, op3_q;
  logic [TICK_W-1:0] t0_q, t1_q, t2_q, t3_q;
  logic [BAR_W-1:0]  barm_q;
  logic [6:0]        beatc_q, sixc_q;
  logic [38:0]       p_lo_q;
  logic [37:0]       p_hi_q, p_hi2_q;
  logic [18:0]       p_beat_q;
  logic [16:0]       p_six_q;
  logic [39:0]       s_lo_q;
  logic [TICK_W-1:0] tick3_q;
  logic              ovf3_q;
  logic [59:0]       total;

  assign total = {1'b0, p_hi2_q, 21'd0} + {20'd0, s_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v0_q <= req_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q   <= req_i.data.opcode;
      t0_q    <= req_i.data.tick_in;
      barm_q  <= (req_i.data.bar_in == '0) ? '0 : req_i.data.bar_in - BAR_W'(1);
      beatc_q <= (req_i.data.beat_in[7] || req_i.data.beat_in == 8'sd0) ? 7'd0
                 : 7'(req_i.data.beat_in - 8'sd1);
      sixc_q  <= req_i.data.sixteenth_in[7] ? 7'd0 : req_i.data.sixteenth_in[6:0];

      op1_q    <= op0_q;
      t1_q     <= t0_q;
      p_lo_q   <= 39'(barm_q[20:0]) * 39'(bar_sz_q);
      p_hi_q   <= 38'(barm_q[40:21]) * 38'(bar_sz_q);
      p_beat_q <= 19'(beatc_q) * 19'(beat_sz_q);
      p_six_q  <= 17'(sixc_q) * 17'(six_sz_q);

      op2_q   <= op1_q;
      t2_q    <= t1_q;
      p_hi2_q <= p_hi_q;
      s_lo_q  <= 40'(p_lo_q) + 40'(p_beat_q) + 40'(p_six_q);

      op3_q <= op2_q;
      t3_q  <= t2_q;
      if (op2_q == OP_REBUILD) begin
        // Anything above the tick range saturates and raises the flag.
        if (total[59:TICK_W] != '0) begin
          tick3_q <= '1;
          ovf3_q  <= 1'b1;
        end else begin
          tick3_q <= total[TICK_W-1:0];
          ovf3_q  <= 1'b0;
        end
      end else begin
        tick3_q <= '0;
        ovf3_q  <= 1'b0;
      end
    end
  end

  // Bar chain: tick count divided by the bar size.
  logic                va [A_N+1];
  logic [BAR_SZ_W-1:0] ra [A_N+1];
  logic [TICK_W-1:0]   na [A_N+1];
  logic [PA_W-1:0]     pa [A_N+1];

  assign va[0] = v3_q;
  assign ra[0] = '0;
  assign na[0] = t3_q;
  assign pa[0] = {op3_q, tick3_q, ovf3_q};

  for (genvar i = 0; i < A_N; i++) begin : g_bar
    tbb_div_cell #(.RW(BAR_SZ_W), .NW(TICK_W), .PW(PA_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .div_i(bar_sz_q),
      .valid_i(va[i]), .rem_i(ra[i]), .num_i(na[i]), .pay_i(pa[i]),
      .valid_o(va[i+1]), .rem_o(ra[i+1]), .num_o(na[i+1]), .pay_o(pa[i+1])
    );
  end

  // Beat chain: the bar remainder is below 64 beats, so six steps suffice.
  logic                 vb [B_N+1];
  logic [BEAT_SZ_W-1:0] rb [B_N+1];
  logic [B_N-1:0]       nb [B_N+1];
  logic [PB_W-1:0]      pb [B_N+1];

  assign vb[0] = va[A_N];
  assign rb[0] = ra[A_N][BAR_SZ_W-1:B_N];
  assign nb[0] = ra[A_N][B_N-1:0];
  assign pb[0] = {na[A_N], pa[A_N]};

  for (genvar i = 0; i < B_N; i++) begin : g_beat
    tbb_div_cell #(.RW(BEAT_SZ_W), .NW(B_N), .PW(PB_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .div_i(beat_sz_q),
      .valid_i(vb[i]), .rem_i(rb[i]), .num_i(nb[i]), .pay_i(pb[i]),
      .valid_o(vb[i+1]), .rem_o(rb[i+1]), .num_o(nb[i+1]), .pay_o(pb[i+1])
    );
  end

  // Sixteenth chain: a beat remainder is always below eight sixteenths.
  logic                vc [C_N+1];
  logic [SIX_SZ_W-1:0] rc [C_N+1];
  logic [C_N-1:0]      nc [C_N+1];
  logic [PC_W-1:0]     pc [C_N+1];

  assign vc[0] = vb[B_N];
  assign rc[0] = {1'b0, rb[B_N][BEAT_SZ_W-1:C_N]};
  assign nc[0] = rb[B_N][C_N-1:0];
  assign pc[0] = {nb[B_N], pb[B_N]};

  for (genvar i = 0; i < C_N; i++) begin : g_six
    tbb_div_cell #(.RW(SIX_SZ_W), .NW(C_N), .PW(PC_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .div_i(six_sz_q),
      .valid_i(vc[i]), .rem_i(rc[i]), .num_i(nc[i]), .pay_i(pc[i]),
      .valid_o(vc[i+1]), .rem_o(rc[i+1]), .num_o(nc[i+1]), .pay_o(pc[i+1])
    );
  end

  // Result assembly.
  logic [PC_W-1:0] last_pay;
  logic            last_op;

  assign last_pay = pc[C_N];
  assign last_op  = last_pay[PA_W-1];

  always_comb begin
    res = '0;
    res.tick_out = last_pay[TICK_W:1];
    res.overflow = last_pay[0];
    if (last_op == OP_SPLIT) begin
      res.bar_out       = {1'b0, last_pay[PB_W-1:PA_W]} + BAR_W'(1);
      res.beat_out      = last_pay[PC_W-1:PB_W] + 6'd1;
      res.sixteenth_out = nc[C_N];
      res.sub_ticks     = rc[C_N];
    end
  end

  // Output register with one skid entry behind it.
  logic out_free;
  assign out_free = !out_v_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= vc[C_N];
      end
    end else if (en && vc[C_N]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (en && vc[C_N]) begin
      skid_q <= res;
    end
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

  // The skid entry is only ever filled behind a waiting response.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid entry without output response");

  // A parked response stays parked until the output is taken.
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !rsp_o.ready |=> skid_v_q) else $error("skid entry lost");

  // A saturated rebuild always reports the largest tick count.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.overflow |-> rsp_o.data.tick_out == '1)
    else $error("overflow without saturated tick count");

endmodule

// ----- rtl/tbb_div_cell.sv -----
// One restoring division step: shifts in a dividend bit and emits a quotient bit.
module tbb_div_cell #(
  parameter int RW = 18,
  parameter int NW = 40,
  parameter int PW = 42
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [RW-1:0] div_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [RW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [PW-1:0] pay_o
);

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_d;
  logic [NW-1:0] num_d;
  logic          valid_q;
  logic [RW-1:0] rem_q;
  logic [NW-1:0] num_q;
  logic [PW-1:0] pay_q;

  assign trial = {rem_i, num_i[NW-1]};
  assign diff  = trial - {1'b0, div_i};
  assign ge    = trial >= {1'b0, div_i};
  assign rem_d = ge ? diff[RW-1:0] : trial[RW-1:0];
  // Dividend bits leave at the top while quotient bits enter at the bottom.
  assign num_d = {num_i[NW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign pay_o   = pay_q;

endmodule
